@@ design/rll_pkg.sv @@
// Shared sizes, types and saturation helper for the four-pole ladder lowpass.
package rll_pkg;

   localparam int SAMPLE_BITS     = 12;
   localparam int STATE_FRAC_BITS = 18;
   localparam int STATE_BITS      = 24;
   localparam int POLES           = 4;
   localparam int WIDE_BITS       = 64;

   typedef logic [SAMPLE_BITS-1:0]       sample_type;
   typedef logic signed [STATE_BITS-1:0] state_type;
   typedef logic signed [WIDE_BITS-1:0]  wide_type;

   // One hop along the chain of pole cells.
   typedef struct packed {
      logic      valid;
      state_type x;
   } link_type;

   localparam wide_type STATE_MAX = (wide_type'(1) <<< (STATE_BITS - 1)) - wide_type'(1);
   localparam wide_type STATE_MIN = -(wide_type'(1) <<< (STATE_BITS - 1));

   function automatic state_type sat_state(input wide_type v);
      state_type r;
      if (v > STATE_MAX) begin
         r = STATE_MAX[STATE_BITS-1:0];
      end else if (v < STATE_MIN) begin
         r = STATE_MIN[STATE_BITS-1:0];
      end else begin
         r = v[STATE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

@@ design/rll_cell.sv @@
// One-pole lowpass cell: holds one pole value and passes its new value on.
module rll_cell
   import rll_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  sample_type cut,
   input  link_type   link_in,
   output link_type   link_out
);

   localparam int DIFF_BITS = STATE_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + SAMPLE_BITS + 1;

   state_type p_ff, p_in;
   logic      valid_ff, valid_in;

   logic signed [DIFF_BITS-1:0] diff;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [PROD_BITS-1:0] step;
   wide_type                    sum;

   // The pole moves toward its input by cut/2^SAMPLE_BITS of the gap, rounded down.
   always_comb begin
      diff     = DIFF_BITS'($signed(link_in.x)) - DIFF_BITS'($signed(p_ff));
      prod     = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, cut}));
      step     = prod >>> SAMPLE_BITS;
      sum      = WIDE_BITS'($signed(p_ff)) + WIDE_BITS'(step);
      p_in     = link_in.valid ? sat_state(sum) : p_ff;
      valid_in = link_in.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         p_ff     <= p_in;
         valid_ff <= valid_in;
      end
   end

   assign link_out.valid = valid_ff;
   assign link_out.x     = p_ff;

endmodule

@@ design/resonant_ladder_lowpass_4pole.sv @@
// Top level of the four-pole resonant ladder lowpass filter.
//
// The req channel carries one item per audio sample: the offset-binary
// sample and its own cutoff and resonance control values. The rsp channel
// returns exactly one item per accepted sample: the filtered sample in
// offset binary and a flag for an upward crossing of midscale.
// An item is accepted in a cycle where req_valid is high and req_stall low.
// The first cycle centres the sample and subtracts the clamped, scaled
// feedback from the fourth pole. The item then walks through a row of four
// pole cells, one cell per cycle, then a conversion register, and reaches
// the rsp register. A new item is taken only once the previous one has
// left the input stage, the pole cells and the conversion register,
// because its feedback needs the fourth pole that the previous item
// leaves behind and the conversion register must be empty.
// While the receiver holds rsp_stall high the result stays on the rsp
// ports; the next item may still be accepted and run, and its result then
// waits in the conversion register, holding req_stall high until it moves.
// Synchronous reset clears the poles, the previous sample and all valid bits.
module resonant_ladder_lowpass_4pole
   import rll_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  sample_type req_audio_in,
   input  sample_type req_cutoff_ctl,
   input  sample_type req_resonance_ctl,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output sample_type rsp_audio_out,
   output logic       rsp_rising_cross
);

   localparam int FB_BITS  = STATE_FRAC_BITS + 2;
   localparam int FBP_BITS = FB_BITS + SAMPLE_BITS + 1;

   localparam sample_type MID_SAMPLE = sample_type'(1) << (SAMPLE_BITS - 1);
   localparam wide_type   ONE_WIDE   = wide_type'(1) <<< STATE_FRAC_BITS;
   localparam wide_type   MID_WIDE   = wide_type'(1) <<< (SAMPLE_BITS - 1);
   localparam wide_type   SMAX_WIDE  = (wide_type'(1) <<< SAMPLE_BITS) - wide_type'(1);

   link_type links [POLES+1];

   logic       accept;
   logic       busy;
   logic       rsp_load;

   logic       v0_ff, v0_in;
   state_type  x0_ff, x0_in;
   sample_type cut_ff, cut_in;
   logic       cross_ff, cross_in;
   sample_type prev_ff, prev_in;
   logic       done_valid_ff, done_valid_in;
   sample_type done_audio_ff, done_audio_in;
   logic       done_cross_ff, done_cross_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_audio_ff, rsp_audio_in;
   logic       rsp_cross_ff, rsp_cross_in;

   logic signed [SAMPLE_BITS:0]  s_diff;
   wide_type                     centred;
   wide_type                     fb_wide;
   logic signed [FB_BITS-1:0]    fb;
   logic signed [FBP_BITS-1:0]   fb_prod;
   logic signed [FBP_BITS-1:0]   fb_term;
   wide_type                     x_wide;
   wide_type                     y_wide;
   sample_type                   y;

   // Only one item is in the filter at a time; its result may still wait
   // in the conversion register while the rsp register is stalled.
   assign busy      = v0_ff | links[1].valid | links[2].valid | links[3].valid
                    | links[4].valid | done_valid_ff;
   assign req_stall = busy;
   assign accept    = req_valid & ~busy;
   assign rsp_load  = done_valid_ff & (~rsp_valid_ff | ~rsp_stall);

   // Input stage: centre the sample and subtract the resonance feedback.
   always_comb begin
      s_diff  = $signed({1'b0, req_audio_in}) - $signed({1'b0, MID_SAMPLE});
      centred = (WIDE_BITS'(s_diff) <<< STATE_FRAC_BITS) >>> (SAMPLE_BITS - 1);
      fb_wide = WIDE_BITS'($signed(links[POLES].x));
      if (fb_wide > ONE_WIDE) begin
         fb_wide = ONE_WIDE;
      end else if (fb_wide < -ONE_WIDE) begin
         fb_wide = -ONE_WIDE;
      end
      fb      = fb_wide[FB_BITS-1:0];
      fb_prod = FBP_BITS'(fb) * FBP_BITS'($signed({1'b0, req_resonance_ctl}));
      fb_term = fb_prod >>> (SAMPLE_BITS - 3);
      x_wide  = centred - WIDE_BITS'(fb_term);

      v0_in    = accept;
      x0_in    = accept ? sat_state(x_wide) : x0_ff;
      cut_in   = accept ? req_cutoff_ctl : cut_ff;
      cross_in = accept ? ((req_audio_in > MID_SAMPLE) && (prev_ff < MID_SAMPLE))
                        : cross_ff;
      prev_in  = accept ? req_audio_in : prev_ff;
   end

   assign links[0].valid = v0_ff;
   assign links[0].x     = x0_ff;

   genvar g;
   generate
      for (g = 0; g < POLES; g++) begin : g_pole
         rll_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cut      (cut_ff),
            .link_in  (links[g]),
            .link_out (links[g+1])
         );
      end
   endgenerate

   // Output conversion: fourth pole back to offset binary, saturated.
   always_comb begin
      y_wide = ((WIDE_BITS'($signed(links[POLES].x)) <<< (SAMPLE_BITS - 1))
                >>> STATE_FRAC_BITS) + MID_WIDE;
      if (y_wide < wide_type'(0)) begin
         y = '0;
      end else if (y_wide > SMAX_WIDE) begin
         y = SMAX_WIDE[SAMPLE_BITS-1:0];
      end else begin
         y = y_wide[SAMPLE_BITS-1:0];
      end

      done_valid_in = links[POLES].valid | (done_valid_ff & ~rsp_load);
      done_audio_in = links[POLES].valid ? y : done_audio_ff;
      done_cross_in = links[POLES].valid ? cross_ff : done_cross_ff;

      rsp_valid_in  = rsp_load | (rsp_valid_ff & rsp_stall);
      rsp_audio_in  = rsp_load ? done_audio_ff : rsp_audio_ff;
      rsp_cross_in  = rsp_load ? done_cross_ff : rsp_cross_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         prev_ff       <= '0;
         done_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         v0_ff         <= v0_in;
         prev_ff       <= prev_in;
         done_valid_ff <= done_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff         <= x0_in;
      cut_ff        <= cut_in;
      cross_ff      <= cross_in;
      done_audio_ff <= done_audio_in;
      done_cross_ff <= done_cross_in;
      rsp_audio_ff  <= rsp_audio_in;
      rsp_cross_ff  <= rsp_cross_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_audio_out    = rsp_audio_ff;
   assign rsp_rising_cross = rsp_cross_ff;

endmodule

@@ tb/sv/tb_resonant_ladder_lowpass_4pole.sv @@
// Self-checking testbench for the four-pole resonant ladder lowpass filter.
module tb_resonant_ladder_lowpass_4pole
   import rll_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Fixed-point landmarks of the filter, all in 64-bit signed arithmetic.
   localparam longint MIDSCALE   = longint'(1) <<< (SAMPLE_BITS - 1);
   localparam longint SAMPLE_TOP = (longint'(1) <<< SAMPLE_BITS) - 1;
   localparam longint UNITY      = longint'(1) <<< STATE_FRAC_BITS;
   localparam longint STATE_HI   = (longint'(1) <<< (STATE_BITS - 1)) - 1;
   localparam longint STATE_LO   = -(longint'(1) <<< (STATE_BITS - 1));
   // A resonance value of 512 gives a feedback gain of exactly one.
   localparam int     UNITY_GAIN_RES = 1 << (SAMPLE_BITS - 3);

   localparam int TOTAL_SAMPLES = 1750;
   localparam int DRAIN_POINT   = 1000;   // item that waits for an empty pipe
   localparam int HOLD_AT       = 700;    // results seen before the long receiver hold
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   // Shapes of the random stimulus segments.
   typedef enum int {SEG_NOISE, SEG_SQUARE, SEG_MIDSCALE, SEG_RAMP} segment_kind_type;

   typedef struct packed {
      sample_type audio_out;
      logic       rising_cross;
   } ladder_output_type;

   // One sample waiting to be offered, with the idle cycles that come before it.
   typedef struct {
      sample_type audio;
      sample_type cutoff;
      sample_type resonance;
      int         gap;
      bit         drain;
   } sample_job_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   sample_type req_audio_in = '0;
   sample_type req_cutoff_ctl = '0;
   sample_type req_resonance_ctl = '0;
   logic       rsp_valid;
   logic       rsp_stall;
   sample_type rsp_audio_out;
   logic       rsp_rising_cross;

   logic short_stall = 1'b0;
   logic hold_off = 1'b0;

   sample_job_type    sample_jobs[$];
   ladder_output_type expected_outputs[$];

   // Model of the filter memory: the four poles and the previous sample.
   longint pole_model[POLES] = '{default: 0};
   longint prev_model = 0;

   int gap_count = 0;
   int samples_taken = 0;
   int results_seen = 0;
   int receiver_wait = 0;
   int hold_left = 0;
   bit hold_used = 1'b0;
   int mismatches = 0;
   int cycle_count = 0;

   resonant_ladder_lowpass_4pole dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_audio_in     (req_audio_in),
      .req_cutoff_ctl   (req_cutoff_ctl),
      .req_resonance_ctl(req_resonance_ctl),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_audio_out    (rsp_audio_out),
      .rsp_rising_cross (rsp_rising_cross)
   );

   always #2 clock = ~clock;

   // Both stall sources change only just after a rising edge.
   assign rsp_stall = short_stall | hold_off;

   function automatic longint saturate_state(longint v);
      longint r;
      r = v;
      if (r > STATE_HI) begin
         r = STATE_HI;
      end else if (r < STATE_LO) begin
         r = STATE_LO;
      end
      return r;
   endfunction

   // Advances the ladder model by one accepted sample: feedback from the old
   // fourth pole, four one-pole stages, then conversion back to offset binary.
   function automatic void predict(sample_type audio, sample_type cutoff,
                                   sample_type resonance);
      longint            centred;
      longint            fb;
      longint            x;
      longint            p;
      longint            y;
      int                i;
      ladder_output_type o;
      o.rising_cross = (longint'(audio) > MIDSCALE) && (prev_model < MIDSCALE);
      prev_model = longint'(audio);
      centred = ((longint'(audio) - MIDSCALE) * UNITY) >>> (SAMPLE_BITS - 1);
      fb = pole_model[POLES-1];
      if (fb > UNITY) begin
         fb = UNITY;
      end else if (fb < -UNITY) begin
         fb = -UNITY;
      end
      x = saturate_state(centred - ((fb * longint'(resonance)) >>> (SAMPLE_BITS - 3)));
      for (i = 0; i < POLES; i++) begin
         p = pole_model[i];
         p = saturate_state(p + (((x - p) * longint'(cutoff)) >>> SAMPLE_BITS));
         pole_model[i] = p;
         x = p;
      end
      y = MIDSCALE + ((pole_model[POLES-1] * MIDSCALE) >>> STATE_FRAC_BITS);
      if (y < 0) begin
         y = 0;
      end else if (y > SAMPLE_TOP) begin
         y = SAMPLE_TOP;
      end
      o.audio_out = sample_type'(y);
      expected_outputs.push_back(o);
   endfunction

   function automatic void add_job(sample_type audio, sample_type cutoff,
                                   sample_type resonance);
      sample_job_type job;
      job.audio     = audio;
      job.cutoff    = cutoff;
      job.resonance = resonance;
      job.gap       = int'($urandom_range(0, 8));
      job.drain     = (sample_jobs.size() == DRAIN_POINT);
      sample_jobs.push_back(job);
   endfunction

   // Sender: offers queued items after their idle gaps and feeds the model
   // with every item the block accepts.
   always @(posedge clock) begin : driver
      sample_job_type job;
      logic           next_valid;
      logic           present;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else begin
         next_valid = req_valid;
         present    = 1'b0;
         if (req_valid && !req_stall) begin
            predict(req_audio_in, req_cutoff_ctl, req_resonance_ctl);
            samples_taken++;
            next_valid = 1'b0;
         end
         if (!next_valid && sample_jobs.size() != 0) begin
            // A drain item waits until every expected result has come back.
            if (!sample_jobs[0].drain || expected_outputs.size() == 0) begin
               if (gap_count < sample_jobs[0].gap) begin
                  gap_count++;
               end else begin
                  job        = sample_jobs.pop_front();
                  gap_count  = 0;
                  present    = 1'b1;
                  next_valid = 1'b1;
               end
            end
         end
         req_valid <= next_valid;
         if (present) begin
            req_audio_in      <= job.audio;
            req_cutoff_ctl    <= job.cutoff;
            req_resonance_ctl <= job.resonance;
         end
      end
   end

   // Receiver: checks each result and draws a short stall after it.
   always @(posedge clock) begin : monitor
      ladder_output_type expected_out;
      logic              next_stall;
      if (reset) begin
         short_stall <= 1'b0;
         receiver_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_outputs.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected result %0d: audio_out %0d rising_cross %0d",
                           results_seen, rsp_audio_out, rsp_rising_cross);
               end
            end else begin
               expected_out = expected_outputs.pop_front();
               if (rsp_audio_out !== expected_out.audio_out ||
                   rsp_rising_cross !== expected_out.rising_cross) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("result %0d: expected audio_out %0d rising_cross %0d, got audio_out %0d rising_cross %0d",
                              results_seen, expected_out.audio_out,
                              expected_out.rising_cross, rsp_audio_out,
                              rsp_rising_cross);
                  end
               end
            end
            receiver_wait = int'($urandom_range(0, 8));
         end
         next_stall = (receiver_wait != 0);
         if (next_stall) begin
            receiver_wait--;
         end
         short_stall <= next_stall;
      end
   end

   // One long receiver hold while the sender keeps offering items.
   always @(posedge clock) begin : receiver_hold
      if (!reset) begin
         if (!hold_used && results_seen >= HOLD_AT) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            hold_off <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) begin
               hold_off <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("resonant_ladder_lowpass_4pole verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      segment_kind_type seg_kind;
      int               seg_len;
      int               k;
      int               half;
      int               ramp_start;
      int               ramp_inc;
      sample_type       seg_cut;
      sample_type       seg_res;
      sample_type       sq_hi;
      sample_type       sq_lo;
      sample_type       audio;
      sample_type       cutoff;
      sample_type       resonance;

      // Full-scale steps with no feedback drive the output into both rails.
      repeat (16) add_job(sample_type'(SAMPLE_TOP), sample_type'(SAMPLE_TOP), '0);
      repeat (16) add_job('0, sample_type'(SAMPLE_TOP), '0);
      // A square wave under maximum resonance clamps the feedback.
      for (k = 0; k < 32; k++) begin
         add_job((k % 2 == 0) ? sample_type'(SAMPLE_TOP) : '0,
                 sample_type'(SAMPLE_TOP), sample_type'(SAMPLE_TOP));
      end
      // Unity feedback gain with a moderate cutoff.
      for (k = 0; k < 24; k++) begin
         add_job((k % 8 < 4) ? sample_type'(SAMPLE_TOP) : '0,
                 sample_type'(1024), sample_type'(UNITY_GAIN_RES));
      end
      // Around midscale: the exact midscale value is neither above nor below.
      add_job(sample_type'(MIDSCALE - 1), sample_type'(2000), '0);
      add_job(sample_type'(MIDSCALE), sample_type'(2000), '0);
      add_job(sample_type'(MIDSCALE + 1), sample_type'(2000), '0);
      add_job(sample_type'(MIDSCALE - 1), sample_type'(2000), '0);
      add_job(sample_type'(MIDSCALE + 1), sample_type'(2000), '0);
      add_job(sample_type'(MIDSCALE + 1), sample_type'(2000), '0);
      add_job(sample_type'(MIDSCALE), sample_type'(2000), '0);
      add_job(sample_type'(MIDSCALE + 1), sample_type'(2000), '0);
      // A zero cutoff freezes the poles.
      repeat (8) begin
         add_job(sample_type'($urandom_range(0, 4095)), '0,
                 sample_type'($urandom_range(0, 4095)));
      end

      while (sample_jobs.size() < TOTAL_SAMPLES) begin
         seg_kind   = segment_kind_type'($urandom_range(0, 3));
         seg_len    = int'($urandom_range(10, 60));
         seg_cut    = sample_type'($urandom_range(0, 4095));
         seg_res    = sample_type'($urandom_range(0, 4095));
         sq_hi      = sample_type'($urandom_range(2048, 4095));
         sq_lo      = sample_type'($urandom_range(0, 2048));
         half       = int'($urandom_range(1, 6));
         ramp_start = int'($urandom_range(0, 4095));
         ramp_inc   = int'($urandom_range(1, 64));
         for (k = 0; k < seg_len && sample_jobs.size() < TOTAL_SAMPLES; k++) begin
            case (seg_kind)
               SEG_NOISE: begin
                  audio = sample_type'($urandom_range(0, 4095));
               end
               SEG_SQUARE: begin
                  audio = ((k / half) % 2 == 0) ? sq_hi : sq_lo;
               end
               SEG_MIDSCALE: begin
                  audio = sample_type'(MIDSCALE - 1 + longint'($urandom_range(0, 2)));
               end
               SEG_RAMP: begin
                  audio = sample_type'(ramp_start + k * ramp_inc);
               end
               default: begin
                  audio = '0;
               end
            endcase
            cutoff    = ($urandom_range(0, 3) == 0) ?
                        sample_type'($urandom_range(0, 4095)) : seg_cut;
            resonance = ($urandom_range(0, 3) == 0) ?
                        sample_type'($urandom_range(0, 4095)) : seg_res;
            add_job(audio, cutoff, resonance);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (samples_taken < TOTAL_SAMPLES || expected_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && results_seen == TOTAL_SAMPLES) begin
         $display("resonant_ladder_lowpass_4pole verification clean");
      end else begin
         $display("resonant_ladder_lowpass_4pole verification failed");
      end
      $finish;
   end

endmodule
